@@ rtl/clsrng_pkg.sv @@
// ----------------------------------------------------------------------------
// clsrng_pkg
// Constants, modular fold helpers and the controller-to-datapath command
// struct for the combined congruential generator with shuffle table.
// ----------------------------------------------------------------------------
package clsrng_pkg;

   localparam int VALUE_W = 31;

   localparam logic [30:0] MOD_A    = 31'd2147483563;
   localparam logic [30:0] MOD_B    = 31'd2147483399;
   localparam logic [15:0] MUL_A    = 16'd40014;
   localparam logic [15:0] MUL_B    = 16'd40692;
   localparam logic [30:0] INIT_A   = 31'd1;
   localparam logic [30:0] INIT_B   = 31'd123456789;
   localparam logic [30:0] WRAP_ADD = MOD_A - 31'd1;

   // 2^31 mod M for each modulus
   localparam logic [31:0] FOLD_A = 32'h8000_0000 - 32'(MOD_A);
   localparam logic [31:0] FOLD_B = 32'h8000_0000 - 32'(MOD_B);

   localparam int PROD_W = VALUE_W + 16;

   typedef struct packed {
      logic seed_load;  // load both generators from the seed register
      logic prod_load;  // register generator products and slot estimate
      logic x_step;     // reduce first product into first generator
      logic y_step;     // reduce second product into second generator
      logic fill_en;    // write reduced first generator into table
      logic fill_last;  // same value also becomes the last output
      logic slot_read;  // resolve slot and read the table
      logic commit;     // produce the output word and refill the slot
   } cmd_type;

   // hi*2^31 + lo == hi*FOLD + lo (mod M); sum stays below 2*M
   function automatic logic [30:0] fold_a(input logic [PROD_W-1:0] p);
      logic [31:0] f;
      f = 32'(p[30:0]) + 32'(p[PROD_W-1:31]) * FOLD_A;
      return (f >= 32'(MOD_A)) ? 31'(f - 32'(MOD_A)) : f[30:0];
   endfunction

   function automatic logic [30:0] fold_b(input logic [PROD_W-1:0] p);
      logic [31:0] f;
      f = 32'(p[30:0]) + 32'(p[PROD_W-1:31]) * FOLD_B;
      return (f >= 32'(MOD_B)) ? 31'(f - 32'(MOD_B)) : f[30:0];
   endfunction

endpackage

@@ rtl/clsrng_ctrl.sv @@
// ----------------------------------------------------------------------------
// clsrng_ctrl
// Sequencer: accepts a request word, runs the reseed / table fill loop when
// asked, then steps through the draw states (product, slot read, commit) and owns the output valid.
// ----------------------------------------------------------------------------
module clsrng_ctrl
   import clsrng_pkg::*;
#(
   parameter int TABLE_SIZE = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_restart,
   output logic                          req_stall,
   input  logic                          rsp_stall,
   output logic                          rsp_valid,
   output cmd_type                       cmd,
   output logic [$clog2(TABLE_SIZE)-1:0] fill_slot
);

   localparam int IW = $clog2(TABLE_SIZE);
   localparam int CW = $clog2(TABLE_SIZE + 8);

   typedef enum logic [6:0] {
      ST_IDLE      = 7'b0000001,
      ST_SEED      = 7'b0000010,
      ST_FILL_MUL  = 7'b0000100,
      ST_FILL_RED  = 7'b0001000,
      ST_DRAW_MUL  = 7'b0010000,
      ST_DRAW_SLOT = 7'b0100000,
      ST_DRAW_DONE = 7'b1000000
   } state_type;

   state_type         state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign fill_slot = count_ff[IW-1:0];

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = req_restart ? ST_SEED : ST_DRAW_MUL;
            end
         end
         ST_SEED: begin
            cmd.seed_load = 1'b1;
            count_in      = CW'(TABLE_SIZE + 7);
            state_in      = ST_FILL_MUL;
         end
         ST_FILL_MUL: begin
            cmd.prod_load = 1'b1;
            state_in      = ST_FILL_RED;
         end
         ST_FILL_RED: begin
            cmd.x_step    = 1'b1;
            cmd.fill_en   = (count_ff < CW'(TABLE_SIZE));
            cmd.fill_last = (count_ff == '0);
            if (count_ff == '0) begin
               state_in = ST_DRAW_MUL;
            end else begin
               count_in = count_ff - CW'(1);
               state_in = ST_FILL_MUL;
            end
         end
         ST_DRAW_MUL: begin
            cmd.prod_load = 1'b1;
            state_in      = ST_DRAW_SLOT;
         end
         ST_DRAW_SLOT: begin
            cmd.x_step    = 1'b1;
            cmd.y_step    = 1'b1;
            cmd.slot_read = 1'b1;
            state_in      = ST_DRAW_DONE;
         end
         ST_DRAW_DONE: begin
            // wait here until the output register can take the new word
            if (out_free) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ rtl/clsrng_dp.sv @@
// ----------------------------------------------------------------------------
// clsrng_dp
// Datapath: seed register, both generators with their constant multipliers
// and modular folds, slot divider, shuffle table memory and output register.
// ----------------------------------------------------------------------------
module clsrng_dp
   import clsrng_pkg::*;
#(
   parameter int TABLE_SIZE = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [30:0]                   csr_wr_data,
   input  cmd_type                       cmd,
   input  logic [$clog2(TABLE_SIZE)-1:0] fill_slot,
   output logic [30:0]                   rsp_random_value
);

   localparam int    IW        = $clog2(TABLE_SIZE);
   localparam int    QW        = IW + 1;
   localparam longint SLOT_DIV = 1 + (longint'(MOD_A) - 1) / TABLE_SIZE;
   // floor(2^32 / SLOT_DIV): quotient estimate is exact or one short
   localparam longint RECIP    = (longint'(1) << 32) / SLOT_DIV;
   localparam int    RW        = $clog2(RECIP + 1);

   localparam logic [RW-1:0] RECIP_V    = RW'(RECIP);
   localparam logic [32:0]   SLOT_DIV_V = 33'(SLOT_DIV);

   logic [30:0]          seed_ff;
   logic [30:0]          x_ff, y_ff, last_ff, out_ff;
   logic [PROD_W-1:0]    px_ff, py_ff;
   logic [QW-1:0]        q0_ff;
   logic [IW-1:0]        slot_ff;
   logic [30:0]          rd_data_ff;
   logic                 rd_valid_ff;
   logic [TABLE_SIZE-1:0] valid_ff;
   logic [30:0]          table_mem [TABLE_SIZE];

   logic [30:0]          seed_red, seed_use;
   logic [30:0]          x_next, y_next;
   logic [31+RW-1:0]     qprod;
   logic [32:0]          thr;
   logic [QW-1:0]        q1;
   logic [IW-1:0]        slot;
   logic [30:0]          entry;
   logic [31:0]          draw;
   logic                 wr_en;
   logic [IW-1:0]        wr_addr;
   logic [30:0]          wr_data;

   assign seed_red = (seed_ff >= MOD_A) ? (seed_ff - MOD_A) : seed_ff;
   assign seed_use = (seed_red == '0) ? 31'd1 : seed_red;

   assign x_next = fold_a(px_ff);
   assign y_next = fold_b(py_ff);

   // slot = last / SLOT_DIV via reciprocal estimate plus one correction
   assign qprod = last_ff * RECIP_V;
   assign thr   = (33'(q0_ff) + 33'd1) * SLOT_DIV_V;
   assign q1    = ({2'b00, last_ff} >= thr) ? (q0_ff + QW'(1)) : q0_ff;
   assign slot  = (q1 >= QW'(TABLE_SIZE)) ? IW'(TABLE_SIZE - 1) : q1[IW-1:0];

   assign entry = rd_valid_ff ? rd_data_ff : '0;
   // entry - y, wrapped into 1..WRAP_ADD when not positive
   assign draw  = (entry > y_ff) ? (32'(entry) - 32'(y_ff))
                                 : (32'(entry) + 32'(WRAP_ADD) - 32'(y_ff));

   assign wr_en   = cmd.fill_en || cmd.commit;
   assign wr_addr = cmd.commit ? slot_ff : fill_slot;
   assign wr_data = cmd.commit ? x_ff : x_next;

   assign rsp_random_value = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff  <= 31'd1;
         x_ff     <= INIT_A;
         y_ff     <= INIT_B;
         last_ff  <= '0;
         valid_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            seed_ff <= csr_wr_data;
         end
         if (cmd.seed_load) begin
            x_ff <= seed_use;
            y_ff <= seed_use;
         end
         if (cmd.x_step) begin
            x_ff <= x_next;
         end
         if (cmd.y_step) begin
            y_ff <= y_next;
         end
         if (cmd.fill_last) begin
            last_ff <= x_next;
         end
         if (cmd.commit) begin
            last_ff <= draw[30:0];
         end
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.prod_load) begin
         px_ff <= x_ff * MUL_A;
         py_ff <= y_ff * MUL_B;
         q0_ff <= QW'(qprod >> 32);
      end
      if (cmd.slot_read) begin
         slot_ff     <= slot;
         rd_valid_ff <= valid_ff[slot];
      end
      if (cmd.commit) begin
         out_ff <= draw[30:0];
      end
   end

   // shuffle table: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[wr_addr] <= wr_data;
      end
      if (cmd.slot_read) begin
         rd_data_ff <= table_mem[slot];
      end
   end

endmodule

@@ rtl/combined_lcg_shuffle_rng.sv @@
// Draw: accept, product, slot read, commit, in order; commit waits while a
// stalled output word is held, output valid is registered from the commit,
// and no new request is taken before it. Restart adds one seed load, then
// fill steps, each a multiply state and a fold state of the first generator.
// Reset: generators, seed and last output take their initial values, table
// entries read as zero until written; no clearing pass.
// ----------------------------------------------------------------------------
// combined_lcg_shuffle_rng
// Two combined multiplicative congruential generators with a shuffle table;
// one output word per request word, optional reseed and table refill.
// ----------------------------------------------------------------------------
module combined_lcg_shuffle_rng
   import clsrng_pkg::*;
#(
   parameter int TABLE_SIZE = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [30:0] csr_wr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_restart,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [30:0] rsp_random_value
);

   cmd_type                       cmd;
   logic [$clog2(TABLE_SIZE)-1:0] fill_slot;

   clsrng_ctrl #(
      .TABLE_SIZE (TABLE_SIZE)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_restart (req_restart),
      .req_stall   (req_stall),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .cmd         (cmd),
      .fill_slot   (fill_slot)
   );

   clsrng_dp #(
      .TABLE_SIZE (TABLE_SIZE)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .cmd              (cmd),
      .fill_slot        (fill_slot),
      .rsp_random_value (rsp_random_value)
   );

   // no word can come out the cycle right after a request is taken
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> !$rose(rsp_valid))
      else $error("output word appeared one cycle after request");

   // commit only when the previous word is gone or leaving
   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_valid || !rsp_stall))
      else $error("commit overwrote a stalled output word");

   a_valid_from_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.commit))
      else $error("output valid without a commit");

   // new request is never taken while a draw is in flight
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (cmd.slot_read || cmd.prod_load || cmd.x_step) |-> req_stall)
      else $error("request accepted during a draw");

endmodule

@@ tb/combined_lcg_shuffle_rng_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// combined_lcg_shuffle_rng_checker
// Watches the seed port and both channels, runs its own copy of the two
// congruential generators and the shuffle table, and compares every output
// word with the oldest predicted draw.
// ----------------------------------------------------------------------------
module combined_lcg_shuffle_rng_checker
   import clsrng_pkg::*;
#(
   parameter int TABLE_SIZE = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [30:0] csr_wr_data,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic        req_restart,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [30:0] rsp_random_value,
   output int unsigned pending_words,
   output int unsigned error_count
);

   // width of the value band that maps onto one table slot
   localparam logic [31:0] SLOT_SPAN =
      32'((64'(MOD_A) - 64'd1) / 64'(TABLE_SIZE) + 64'd1);

   logic [30:0] seed_reg;
   logic [30:0] gen_x;
   logic [30:0] gen_y;
   logic [30:0] prev_draw;
   logic [30:0] shuffle [TABLE_SIZE];
   logic [30:0] predicted_draws [$];
   int unsigned mismatches = 0;

   function automatic logic [30:0] mulmod(input logic [30:0] v, input logic [15:0] k,
                                         input logic [30:0] m);
      logic [63:0] p;
      p = 64'(v) * 64'(k);
      return 31'(p % 64'(m));
   endfunction

   function automatic void clear_state();
      seed_reg  = 31'd1;
      gen_x     = INIT_A;
      gen_y     = INIT_B;
      prev_draw = '0;
      for (int i = 0; i < TABLE_SIZE; i++) shuffle[i] = '0;
   endfunction

   // reseed both generators, run the first one through the warm-up and
   // fill the table from the top slot down
   function automatic void reload_table();
      logic [30:0] s;
      s = 31'(64'(seed_reg) % 64'(MOD_A));
      if (s == '0) s = 31'd1;
      gen_x = s;
      gen_y = s;
      for (int n = TABLE_SIZE + 7; n >= 0; n--) begin
         gen_x = mulmod(gen_x, MUL_A, MOD_A);
         if (n < TABLE_SIZE) shuffle[n] = gen_x;
      end
      prev_draw = shuffle[0];
   endfunction

   function automatic logic [30:0] predict_draw(input logic restart);
      logic [31:0] slot;
      longint      diff;
      if (restart) reload_table();
      gen_x = mulmod(gen_x, MUL_A, MOD_A);
      gen_y = mulmod(gen_y, MUL_B, MOD_B);
      slot = 32'(prev_draw) / SLOT_SPAN;
      if (slot >= 32'(TABLE_SIZE)) slot = 32'(TABLE_SIZE - 1);
      diff = shuffle[slot];
      diff = diff - gen_y;
      shuffle[slot] = gen_x;
      if (diff < 1) diff = diff + WRAP_ADD;
      prev_draw = diff[30:0];
      return prev_draw;
   endfunction

   always @(posedge clock) begin
      logic [30:0] want;
      if (reset) begin
         clear_state();
         predicted_draws.delete();
      end else begin
         if (csr_wr_en) seed_reg = csr_wr_data;
         if (rsp_valid && !rsp_stall) begin
            if (predicted_draws.size() == 0) begin
               mismatches++;
               $display("%0t ns: random_value with no draw pending, expected none, actual %0d",
                        $time, rsp_random_value);
            end else begin
               want = predicted_draws.pop_front();
               if (rsp_random_value !== want) begin
                  mismatches++;
                  $display("%0t ns: random_value mismatch, expected %0d, actual %0d",
                           $time, want, rsp_random_value);
               end
            end
         end
         if (req_valid && !req_stall) predicted_draws.push_back(predict_draw(req_restart));
      end
      pending_words <= predicted_draws.size();
      error_count   <= mismatches;
   end

endmodule

@@ tb/combined_lcg_shuffle_rng_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// combined_lcg_shuffle_rng_tb
// Drives draw requests and seed writes into the generator, with bursty
// requests and a randomly mode-switched output stall; a side checker predicts and
// compares every output word.
// ----------------------------------------------------------------------------
module combined_lcg_shuffle_rng_tb;
   import clsrng_pkg::*;

   localparam int TABLE_SIZE   = 32;
   localparam int DRAIN_CYCLES = 120;   // covers the restart path with room to spare
   localparam int RANDOM_WORDS = 1530;
   localparam int PHASES       = 8;

   typedef enum logic [1:0] {
      RX_FREE,
      RX_LIGHT,
      RX_HEAVY,
      RX_PERIODIC
   } rx_mode_type;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        csr_wr_en   = 1'b0;
   logic [30:0] csr_wr_data = '0;
   logic        req_valid   = 1'b0;
   logic        req_restart = 1'b0;
   logic        rsp_stall   = 1'b0;
   logic        req_stall;
   logic        rsp_valid;
   logic [30:0] rsp_random_value;

   int unsigned pending_words;
   int unsigned error_count;

   int unsigned words_sent    = 0;
   int unsigned restarts_sent = 0;
   int unsigned seeds_set     = 0;

   rx_mode_type rx_mode   = RX_FREE;
   int unsigned mode_left = 0;

   combined_lcg_shuffle_rng #(
      .TABLE_SIZE (TABLE_SIZE)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_restart      (req_restart),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_random_value (rsp_random_value)
   );

   combined_lcg_shuffle_rng_checker #(
      .TABLE_SIZE (TABLE_SIZE)
   ) u_check (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_restart      (req_restart),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_random_value (rsp_random_value),
      .pending_words    (pending_words),
      .error_count      (error_count)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // output stall: pick a mode, hold it for a while, then pick again
   always @(posedge clock) begin
      if (mode_left == 0) begin
         rx_mode   <= rx_mode_type'($urandom_range(0, 3));
         mode_left <= $urandom_range(20, 300);
      end else begin
         mode_left <= mode_left - 1;
      end
      case (rx_mode)
         RX_FREE:     rsp_stall <= 1'b0;
         RX_LIGHT:    rsp_stall <= ($urandom_range(0, 3) == 0);
         RX_HEAVY:    rsp_stall <= ($urandom_range(0, 1) == 0);
         RX_PERIODIC: rsp_stall <= ((mode_left % 8) < 3);
         default:     rsp_stall <= 1'b0;
      endcase
   end

   // hold the word until the block takes it
   task automatic send_word(input logic restart);
      req_valid   <= 1'b1;
      req_restart <= restart;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      words_sent++;
      if (restart) restarts_sent++;
   endtask

   task automatic idle_gap(input int unsigned n);
      if (n != 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // wait until every predicted draw has come out, plus a margin
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_words != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_seed(input logic [30:0] s);
      settle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= s;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      seeds_set++;
   endtask

   function automatic logic [30:0] pick_seed();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return 31'h7FFF_FFFF;
         2:       return MOD_A - 31'd1;
         3:       return MOD_B;
         4:       return MOD_A;
         default: return 31'($urandom);
      endcase
   endfunction

   initial begin
      int unsigned per_phase;
      int unsigned remaining;
      int unsigned burst;
      int unsigned restart_odds;
      bit          gappy;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // draws straight from the reset state, table still all zero
      repeat (3) send_word(1'b0);
      // restart on the reset seed
      send_word(1'b1);
      send_word(1'b0);
      // zero seed acts as one
      write_seed('0);
      send_word(1'b1);
      send_word(1'b0);
      // seeds at or past the first modulus get reduced
      write_seed(31'h7FFF_FFFF);
      send_word(1'b1);
      send_word(1'b0);
      write_seed(MOD_A);
      send_word(1'b1);
      // second generator stuck at zero
      write_seed(MOD_B);
      send_word(1'b1);
      send_word(1'b0);
      send_word(1'b0);
      write_seed(MOD_A - 31'd1);
      send_word(1'b1);
      send_word(1'b0);
      // restarts back to back
      send_word(1'b1);
      send_word(1'b1);

      per_phase = RANDOM_WORDS / PHASES;
      for (int p = 0; p < PHASES; p++) begin
         write_seed(pick_seed());
         restart_odds = $urandom_range(4, 32);
         gappy        = (p % 3 != 0);
         remaining    = per_phase;
         while (remaining > 0) begin
            burst = $urandom_range(1, 24);
            if (burst > remaining) burst = remaining;
            repeat (burst) send_word($urandom_range(0, restart_odds - 1) == 0);
            remaining -= burst;
            if (gappy)
               idle_gap(($urandom_range(0, 7) == 0) ? $urandom_range(8, 40)
                                                    : $urandom_range(0, 4));
         end
      end
      write_seed(31'd1);
      send_word(1'b1);
      send_word(1'b0);

      settle();
      $display("Drew %0d words, %0d of them with a restart, over %0d seed settings.",
               words_sent, restarts_sent, seeds_set);
      $display("Output word mismatches: %0d", error_count);
      if (error_count == 0) begin
         $display("** combined_lcg_shuffle_rng: PASSED **");
      end else begin
         $display("** combined_lcg_shuffle_rng: FAILED **");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("Timed out with %0d draws outstanding.", pending_words);
      $display("** combined_lcg_shuffle_rng: FAILED **");
      $finish;
   end

endmodule

@@ files.f @@
rtl/clsrng_pkg.sv
rtl/clsrng_ctrl.sv
rtl/clsrng_dp.sv
rtl/combined_lcg_shuffle_rng.sv
tb/combined_lcg_shuffle_rng_checker.sv
tb/combined_lcg_shuffle_rng_tb.sv
